// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define QCPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define QCPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/qcpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Quoted coordinate pair parser package
// Character codes, fixed-point scaling constants and shared transaction types.
// ----------------------------------------------------------------------------
package qcpp_pkg;

  // Character codes recognized by the parser.
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Fixed-point format: values are scaled by ten to the FRAC_DIGITS.
  localparam int FRAC_DIGITS = 4;
  localparam int FRAC_W      = 3;
  localparam int VALUE_W     = 32;
  localparam int POW_W       = 24;
  localparam int TERM_W      = 28;

  // One input transaction: a text byte and its end-of-line mark.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] x_value;
    logic [VALUE_W-1:0] y_value;
  } out_item_t;

  // Contents of the input register.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  // Result produced by the parser for the byte it consumes.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  // Powers of ten used as digit weights.
  function automatic logic [POW_W-1:0] pow10_f(input logic [FRAC_W-1:0] n);
    logic [POW_W-1:0] p;
    case (n)
      3'd0:    p = POW_W'(1);
      3'd1:    p = POW_W'(10);
      3'd2:    p = POW_W'(100);
      3'd3:    p = POW_W'(1000);
      3'd4:    p = POW_W'(10000);
      3'd5:    p = POW_W'(100000);
      3'd6:    p = POW_W'(1000000);
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== src/qcpp_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one text byte and its end-of-line mark.
// ----------------------------------------------------------------------------
interface qcpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       line_end;

  modport source (output valid, output text_byte, output line_end, input ready);
  modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

// ===== src/qcpp_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying the found flag and the coordinate pair.
// ----------------------------------------------------------------------------
interface qcpp_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] x_value;
  logic [31:0] y_value;

  modport source (output valid, output found, output x_value, output y_value,
                  input ready);
  modport sink   (input valid, input found, input x_value, input y_value,
                  output ready);
endinterface

// ===== src/qcpp_in_reg.sv =====
// ----------------------------------------------------------------------------
// Input register
// Captures one input transaction and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module qcpp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  qcpp_in_if.sink           in_if,
  input  logic              out_free,
  output qcpp_pkg::stage_t  stage
);

  logic                 valid_r;
  logic                 valid_nxt;
  qcpp_pkg::in_item_t   item_r;
  logic                 take;

  // The held byte is consumed whenever the result register can take its result.
  assign take        = valid_r && out_free;
  assign in_if.ready = !valid_r || out_free;

  // Valid tracking: fill on accept, drain on consume.
  always_comb begin
    valid_nxt = valid_r;
    if (in_if.valid && in_if.ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload capture needs no reset.
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r.text_byte <= in_if.text_byte;
      item_r.line_end  <= in_if.line_end;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

// ===== src/qcpp_parse.sv =====
// ----------------------------------------------------------------------------
// Parser core
// Per-line parse state and its update for one consumed byte.
// ----------------------------------------------------------------------------
module qcpp_parse #(
  parameter int FRAC_DIGITS = qcpp_pkg::FRAC_DIGITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  qcpp_pkg::stage_t  stage,
  input  logic              take,
  output qcpp_pkg::result_t result
);

  typedef struct packed {
    logic [7:0]                    prev_char;
    logic                          armed;
    logic                          inside_quotes;
    logic [1:0]                    buffer_fill;
    logic                          in_fraction;
    logic [qcpp_pkg::FRAC_W-1:0]   frac_digits;
    logic [qcpp_pkg::VALUE_W-1:0]  accum;
    logic [qcpp_pkg::VALUE_W-1:0]  first_value;
    logic [1:0]                    values_found;
    logic                          pair_emitted;
  } parse_state_t;

  parse_state_t st_r;
  parse_state_t st_nxt;

  logic [7:0]                         c;
  logic                               is_quote;
  logic                               is_digit;
  logic                               quoted;
  logic [3:0]                         digit;
  logic [qcpp_pkg::FRAC_W-1:0]        frac_idx;
  logic [qcpp_pkg::TERM_W-1:0]        int_term;
  logic [qcpp_pkg::TERM_W-1:0]        frac_term;
  logic [qcpp_pkg::VALUE_W+4:0]       int_sum;
  logic [qcpp_pkg::VALUE_W:0]         frac_sum;
  logic [qcpp_pkg::VALUE_W-1:0]       int_acc;
  logic [qcpp_pkg::VALUE_W-1:0]       frac_acc;

  assign c        = stage.item.text_byte;
  assign is_quote = (c == qcpp_pkg::CHAR_QUOTE);
  assign digit    = 4'(c - qcpp_pkg::CHAR_ZERO);
  assign frac_idx = qcpp_pkg::FRAC_W'(FRAC_DIGITS - 1) - st_r.frac_digits;

  always_comb begin
    is_digit = c inside {[qcpp_pkg::CHAR_ZERO:qcpp_pkg::CHAR_NINE]};
  end

  // Integer digit: accum * 10 + digit * 10^FRAC_DIGITS, saturating.
  assign int_term = qcpp_pkg::TERM_W'(digit) *
                    qcpp_pkg::TERM_W'(qcpp_pkg::pow10_f(
                      qcpp_pkg::FRAC_W'(FRAC_DIGITS)));
  assign int_sum  = (qcpp_pkg::VALUE_W+5)'({st_r.accum, 3'b000}) +
                    (qcpp_pkg::VALUE_W+5)'({st_r.accum, 1'b0}) +
                    (qcpp_pkg::VALUE_W+5)'(int_term);
  assign int_acc  = (|int_sum[qcpp_pkg::VALUE_W+4:qcpp_pkg::VALUE_W]) ?
                    '1 : int_sum[qcpp_pkg::VALUE_W-1:0];

  // Fraction digit: accum + digit * 10^(remaining places - 1), saturating.
  assign frac_term = qcpp_pkg::TERM_W'(digit) *
                     qcpp_pkg::TERM_W'(qcpp_pkg::pow10_f(frac_idx));
  assign frac_sum  = (qcpp_pkg::VALUE_W+1)'(st_r.accum) +
                     (qcpp_pkg::VALUE_W+1)'(frac_term);
  assign frac_acc  = frac_sum[qcpp_pkg::VALUE_W] ? '1 : frac_sum[qcpp_pkg::VALUE_W-1:0];

  // Next state and result for the byte in the input register.
  always_comb begin
    st_nxt       = st_r;
    result.valid = 1'b0;
    result.item  = '0;
    quoted       = st_r.inside_quotes ^ is_quote;

    if (!st_r.pair_emitted) begin
      if (!st_r.armed) begin
        // Look for the two-character sequence x= to arm.
        if (st_r.prev_char == qcpp_pkg::CHAR_X && c == qcpp_pkg::CHAR_EQ) begin
          st_nxt.armed = 1'b1;
        end
        st_nxt.prev_char = c;
      end else begin
        st_nxt.inside_quotes = quoted;
        if (quoted) begin
          if (st_r.buffer_fill < 2'd2) begin
            st_nxt.buffer_fill = st_r.buffer_fill + 2'd1;
          end
          if (is_quote) begin
            // An opening quote starts a fresh value.
            st_nxt.accum       = '0;
            st_nxt.in_fraction = 1'b0;
            st_nxt.frac_digits = '0;
          end else if (c == qcpp_pkg::CHAR_DOT) begin
            st_nxt.in_fraction = 1'b1;
          end else if (is_digit) begin
            if (!st_r.in_fraction) begin
              st_nxt.accum = int_acc;
            end else if (st_r.frac_digits < qcpp_pkg::FRAC_W'(FRAC_DIGITS)) begin
              st_nxt.accum       = frac_acc;
              st_nxt.frac_digits = st_r.frac_digits + qcpp_pkg::FRAC_W'(1);
            end
          end
        end else if (st_r.buffer_fill > 2'd1) begin
          // A string just closed: store it, and a second one completes the pair.
          st_nxt.buffer_fill = 2'd1;
          if (st_r.values_found == 2'd0) begin
            st_nxt.first_value  = st_r.accum;
            st_nxt.values_found = 2'd1;
          end else begin
            st_nxt.values_found = 2'd2;
            st_nxt.pair_emitted = 1'b1;
            result.valid        = 1'b1;
            result.item.found   = 1'b1;
            result.item.x_value = st_r.first_value;
            result.item.y_value = st_r.accum;
          end
        end
      end
    end

    // End of line: report a miss if no pair was given, then start over.
    if (stage.item.line_end) begin
      if (!st_nxt.pair_emitted) begin
        result.valid = 1'b1;
        result.item  = '0;
      end
      st_nxt = '0;
    end

    if (!stage.valid) begin
      result.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (take) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== src/qcpp_out_reg.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one result transaction on the output channel until it is taken.
// ----------------------------------------------------------------------------
module qcpp_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  qcpp_pkg::result_t  result,
  input  logic               take,
  qcpp_out_if.source         out_if,
  output logic               out_free
);

  logic                 valid_r;
  logic                 valid_nxt;
  qcpp_pkg::out_item_t  item_r;
  logic                 load;

  assign out_free = !valid_r || out_if.ready;
  assign load     = take && result.valid;

  // Valid tracking: set on load, clear once the transaction is taken.
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= result.item;
    end
  end

  assign out_if.valid   = valid_r;
  assign out_if.found   = item_r.found;
  assign out_if.x_value = item_r.x_value;
  assign out_if.y_value = item_r.y_value;

endmodule

// ===== src/quoted_coordinate_pair_parser_core.sv =====
// ----------------------------------------------------------------------------
// Quoted coordinate pair parser
// Takes one text byte per transaction and, per line, reports the two quoted
// values that follow an x= marker as unsigned numbers scaled by
// 10^FRAC_DIGITS (four places by default) and saturating at 32 bits. The pair
// is reported on the byte that closes the second quoted string; a line
// without a pair reports found clear on its last byte. The block accepts one
// byte every cycle: a byte is held in the input register, the parser updates
// its line state from it as the byte is consumed, and any result goes to the
// output register. Throughput drops only while the output register holds a
// result that the sink has not taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quoted_coordinate_pair_parser_core #(
  parameter int FRAC_DIGITS = qcpp_pkg::FRAC_DIGITS
) (
  input  logic        clk,
  input  logic        rst_n,
  qcpp_in_if.sink     in_if,
  qcpp_out_if.source  out_if
);

  qcpp_pkg::stage_t   stage;
  qcpp_pkg::result_t  result;
  logic               out_free;
  logic               take;
  logic               out_miss;
  logic               out_zero;
  logic               mid_line_result;

  // The parser consumes the held byte when the result register has room.
  assign take = stage.valid && out_free;

  qcpp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_free (out_free),
    .stage    (stage)
  );

  qcpp_parse #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .stage  (stage),
    .take   (take),
    .result (result)
  );

  qcpp_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .result   (result),
    .take     (take),
    .out_if   (out_if),
    .out_free (out_free)
  );

  // Conditions watched by the checks below.
  assign out_miss        = out_if.valid && !out_if.found;
  assign out_zero        = (out_if.x_value == 32'd0) && (out_if.y_value == 32'd0);
  assign mid_line_result = result.valid && !stage.item.line_end;

  // Checks on the internal flow.
  `QCPP_ASSERT(a_miss_is_zero, !out_miss || out_zero, "miss result carries nonzero values")
  `QCPP_ASSERT(a_stall_needs_item, in_if.ready || stage.valid, "input stalled while empty")
  `QCPP_ASSERT_NEXT(a_result_loaded, take && result.valid, out_if.valid, "result not presented")
  `QCPP_ASSERT(a_mid_line_found, !mid_line_result || result.item.found, "mid-line miss")

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Quoted coordinate pair parser testbench
// Streams text lines into the parser and predicts the per-line result from a
// behavioral copy of the line state. Every result transaction is checked field
// by field against the oldest prediction. The run covers four handshake
// phases, one long receiver hold-off and full drains between the phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 250;
  localparam int SETTLE_TICKS = 20;

  // Characters used by the generator beyond those of the package.
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  logic clk;
  logic rst_n;

  qcpp_in_if  in_ch ();
  qcpp_out_if out_ch ();

  quoted_coordinate_pair_parser_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Text bytes waiting for the driver and results waiting for the monitor.
  qcpp_pkg::in_item_t  text_queue[$];
  qcpp_pkg::out_item_t line_results[$];
  qcpp_pkg::in_item_t  next_byte;

  int  bytes_pushed;
  int  bytes_accepted;
  int  error_count;
  int  quiet_cycles;
  int  sender_idle_pct;
  int  rcv_stall_pct;
  int  hold_requests;
  int  holds_granted;
  int  hold_left;
  bit  in_taken;

  // Line state of the predictor.
  logic [7:0]  prev_char;
  logic        marker_seen;
  logic        in_string;
  logic [1:0]  fill_count;
  logic        in_frac;
  logic [2:0]  frac_count;
  logic [31:0] acc_value;
  logic [31:0] first_coord;
  logic [1:0]  coords_stored;
  logic        pair_done;

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [63:0] ten_to(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic [31:0] clamp32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  task automatic clear_line_state();
    prev_char     = '0;
    marker_seen   = 1'b0;
    in_string     = 1'b0;
    fill_count    = '0;
    in_frac       = 1'b0;
    frac_count    = '0;
    acc_value     = '0;
    first_coord   = '0;
    coords_stored = '0;
    pair_done     = 1'b0;
  endtask

  // Updates the line state with one byte and returns the result it causes.
  task automatic parse_byte(input qcpp_pkg::in_item_t b, output bit emit,
                            output qcpp_pkg::out_item_t res);
    logic [63:0] digit;
    emit = 1'b0;
    res  = '0;
    if (!pair_done) begin
      if (!marker_seen) begin
        if (prev_char == qcpp_pkg::CHAR_X && b.text_byte == qcpp_pkg::CHAR_EQ)
          marker_seen = 1'b1;
        prev_char = b.text_byte;
      end else begin
        if (b.text_byte == qcpp_pkg::CHAR_QUOTE) begin
          in_string = !in_string;
          if (in_string) begin
            acc_value  = '0;
            in_frac    = 1'b0;
            frac_count = '0;
          end
        end
        if (in_string) begin
          if (fill_count < 2) fill_count = fill_count + 2'd1;
          if (b.text_byte == qcpp_pkg::CHAR_DOT) begin
            in_frac = 1'b1;
          end else if (b.text_byte >= qcpp_pkg::CHAR_ZERO &&
                       b.text_byte <= qcpp_pkg::CHAR_NINE) begin
            digit = 64'(b.text_byte - qcpp_pkg::CHAR_ZERO);
            if (!in_frac) begin
              acc_value = clamp32(64'(acc_value) * 64'd10 +
                                  digit * ten_to(qcpp_pkg::FRAC_DIGITS));
            end else if (frac_count < qcpp_pkg::FRAC_DIGITS) begin
              acc_value = clamp32(64'(acc_value) +
                                  digit * ten_to(qcpp_pkg::FRAC_DIGITS - 1 -
                                                 int'(frac_count)));
              frac_count = frac_count + 3'd1;
            end
          end
        end else if (fill_count > 1) begin
          // A closing quote stores the string's value.
          fill_count = 2'd1;
          if (coords_stored == 0) begin
            first_coord   = acc_value;
            coords_stored = 2'd1;
          end else begin
            coords_stored = 2'd2;
            pair_done     = 1'b1;
            res.found     = 1'b1;
            res.x_value   = first_coord;
            res.y_value   = acc_value;
            emit          = 1'b1;
          end
        end
      end
    end
    if (b.line_end) begin
      if (!pair_done) begin
        res  = '0;
        emit = 1'b1;
      end
      clear_line_state();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // Stimulus helpers.
  task automatic push_byte(input logic [7:0] b, input logic last);
    qcpp_pkg::in_item_t it;
    it.text_byte = b;
    it.line_end  = last;
    text_queue.push_back(it);
    bytes_pushed++;
  endtask

  task automatic push_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] random_digit();
    return qcpp_pkg::CHAR_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] non_quote_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == qcpp_pkg::CHAR_QUOTE) b = 8'($urandom_range(255));
    return b;
  endfunction

  // One quoted number with random sign, length, fraction and clutter.
  task automatic push_quoted_value(input logic last);
    int n_int;
    int n_frac;
    push_byte(qcpp_pkg::CHAR_QUOTE, 1'b0);
    if ($urandom_range(9) == 0) n_int = $urandom_range(12);
    else n_int = $urandom_range(4);
    if ($urandom_range(4) == 0) push_byte(CHAR_MINUS, 1'b0);
    for (int k = 0; k < n_int; k++) push_byte(random_digit(), 1'b0);
    if ($urandom_range(9) < 6) begin
      push_byte(qcpp_pkg::CHAR_DOT, 1'b0);
      n_frac = $urandom_range(6);
      for (int k = 0; k < n_frac; k++) push_byte(random_digit(), 1'b0);
      if ($urandom_range(7) == 0) begin
        push_byte(qcpp_pkg::CHAR_DOT, 1'b0);
        push_byte(random_digit(), 1'b0);
      end
    end
    if ($urandom_range(5) == 0) push_byte(non_quote_byte(), 1'b0);
    push_byte(qcpp_pkg::CHAR_QUOTE, last);
  endtask

  // A random line: mostly marker plus two values, some broken, some noise.
  task automatic push_random_line();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 10) begin
      n = $urandom_range(1, 8);
      for (int k = 0; k < n; k++) push_byte(8'($urandom_range(255)), k == n - 1);
    end else begin
      n = $urandom_range(4);
      for (int k = 0; k < n; k++) push_byte(8'($urandom_range(255)), 1'b0);
      case ($urandom_range(2))
        0: push_text("x=", 1'b0);
        1: push_text("cx=", 1'b0);
        default: push_text("dx=", 1'b0);
      endcase
      if ($urandom_range(3) == 0) push_byte(CHAR_SPACE, 1'b0);
      if (kind < 18) begin
        // Only one value, or a second string left open at the line end.
        if ($urandom_range(1) == 0) begin
          push_quoted_value(1'b1);
        end else begin
          push_quoted_value(1'b0);
          push_byte(qcpp_pkg::CHAR_QUOTE, 1'b0);
          push_byte(random_digit(), 1'b0);
          push_byte(non_quote_byte(), 1'b1);
        end
      end else begin
        push_quoted_value(1'b0);
        n = $urandom_range(2);
        for (int k = 0; k < n; k++)
          push_byte(($urandom_range(1) == 0) ? CHAR_COMMA : non_quote_byte(), 1'b0);
        n = $urandom_range(3);
        push_quoted_value(n == 0);
        for (int k = 0; k < n; k++) push_byte(8'($urandom_range(255)), k == n - 1);
      end
    end
  endtask

  // Waits until every byte is taken and every predicted result has arrived.
  task automatic wait_for_drain();
    while (bytes_accepted != bytes_pushed || line_results.size() != 0) @(negedge clk);
  endtask

  // Sender: holds a transaction until it is taken, idles at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (text_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_byte = text_queue.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.text_byte <= next_byte.text_byte;
        in_ch.line_end  <= next_byte.line_end;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (holds_granted < hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_granted++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Monitor: predicts on accepted bytes, checks accepted results, and keeps
  // the watchdog on cycles without any transaction.
  always @(posedge clk) begin
    bit                  emit;
    bit                  any_fire;
    qcpp_pkg::out_item_t predicted;
    qcpp_pkg::out_item_t want;
    qcpp_pkg::in_item_t  taken;
    in_taken = 1'b0;
    any_fire = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_taken        = 1'b1;
        any_fire        = 1'b1;
        taken.text_byte = in_ch.text_byte;
        taken.line_end  = in_ch.line_end;
        parse_byte(taken, emit, predicted);
        if (emit) line_results.push_back(predicted);
        bytes_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        any_fire = 1'b1;
        if (line_results.size() == 0) begin
          report_mismatch("unexpected result, found", 32'(out_ch.found), 32'd0);
        end else begin
          want = line_results.pop_front();
          if (out_ch.found !== want.found)
            report_mismatch("found", 32'(out_ch.found), 32'(want.found));
          if (out_ch.x_value !== want.x_value)
            report_mismatch("x_value", out_ch.x_value, want.x_value);
          if (out_ch.y_value !== want.y_value)
            report_mismatch("y_value", out_ch.y_value, want.y_value);
        end
      end
      if (any_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("quoted_coordinate_pair_parser_core test failed");
        $finish;
      end
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    bytes_pushed    = 0;
    bytes_accepted  = 0;
    error_count     = 0;
    quiet_cycles    = 0;
    sender_idle_pct = 0;
    rcv_stall_pct   = 0;
    hold_requests   = 0;
    holds_granted   = 0;
    hold_left       = 0;
    in_taken        = 1'b0;
    clear_line_state();
    in_ch.valid     = 1'b0;
    in_ch.text_byte = '0;
    in_ch.line_end  = 1'b0;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed lines: sign, extra fraction digits and a second point after a
    // cx= marker; empty strings; saturation; an unclosed string with a zero
    // byte; a lone byte with no marker.
    push_text("cx=\"-1.23456.7\"\" 9\"", 1'b1);
    push_text("x=\"\"\"\"\"\"", 1'b1);
    push_text("x=\"9999999999\"\".0001\"", 1'b0);
    push_byte(CHAR_SPACE, 1'b1);
    push_text("x=\"12", 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b1);
    wait_for_drain();

    // Random phases; the sender pauses at the end of each until all is back.
    for (int phase = 0; phase < 4; phase++) begin
      int start;
      case (phase)
        0: begin sender_idle_pct = 0;  rcv_stall_pct = 0;  hold_requests++; end
        1: begin sender_idle_pct = 47; rcv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  rcv_stall_pct = 47; end
        default: begin sender_idle_pct = 25; rcv_stall_pct = 25; end
      endcase
      start = bytes_pushed;
      while (bytes_pushed - start < PHASE_BYTES) push_random_line();
      wait_for_drain();
    end

    repeat (SETTLE_TICKS) @(negedge clk);
    if (error_count == 0 && line_results.size() == 0) begin
      $display("quoted_coordinate_pair_parser_core test passed");
    end else begin
      $display("quoted_coordinate_pair_parser_core test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/qcpp_pkg.sv
src/qcpp_in_if.sv
src/qcpp_out_if.sv
src/qcpp_in_reg.sv
src/qcpp_parse.sv
src/qcpp_out_reg.sv
src/quoted_coordinate_pair_parser_core.sv
dv/testbench.sv
